// File: rtl/tsd_pkg.sv
// Shared types, codes and default sizes for the two-stack deque.
package tsd_pkg;

   localparam int SIDE_DEPTH_DEF = 256;
   localparam int DATA_WIDTH_DEF = 32;

   localparam logic [1:0] FUNC_PUSH_FRONT = 2'd0;
   localparam logic [1:0] FUNC_PUSH_BACK  = 2'd1;
   localparam logic [1:0] FUNC_READ       = 2'd2;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_OOR  = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] value;
      logic [8:0]         index;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_data;
      logic [1:0]         status;
      logic [9:0]         count;
      logic               is_empty;
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic finish;
   } cmd_type;

endpackage

// File: rtl/tsd_ctrl.sv
// Controller that accepts words and sequences the indexed read through its read state.
module tsd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [1:0]       req_func,
   output logic             busy,
   output tsd_pkg::cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   assign busy   = (state_ff == ST_READ);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_func == tsd_pkg::FUNC_READ)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.accept = accept;
   assign cmd.finish = (state_ff == ST_READ);

endmodule

// File: rtl/tsd_datapath.sv
// Datapath holding both stack memories, the counts, the end elements and the result register.
module tsd_datapath #(
   parameter int SIDE_DEPTH = tsd_pkg::SIDE_DEPTH_DEF,
   parameter int DATA_WIDTH = tsd_pkg::DATA_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  tsd_pkg::cmd_type cmd,
   input  tsd_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output tsd_pkg::rsp_type rsp_payload
);

   localparam int AW = (SIDE_DEPTH > 1) ? $clog2(SIDE_DEPTH) : 1;
   localparam int CW = $clog2(SIDE_DEPTH + 1);
   localparam int TW = $clog2(2 * SIDE_DEPTH + 1);
   localparam int XW = (TW > 9) ? TW + 1 : 10;

   logic [DATA_WIDTH-1:0] front_mem [SIDE_DEPTH];
   logic [DATA_WIDTH-1:0] back_mem  [SIDE_DEPTH];

   logic [CW-1:0]         fc_ff, fc_in;
   logic [CW-1:0]         bc_ff, bc_in;
   logic [DATA_WIDTH-1:0] front_top_ff, front_top_in;
   logic [DATA_WIDTH-1:0] front_bot_ff, front_bot_in;
   logic [DATA_WIDTH-1:0] back_top_ff, back_top_in;
   logic [DATA_WIDTH-1:0] back_bot_ff, back_bot_in;
   logic [DATA_WIDTH-1:0] front_rd_ff, back_rd_ff;
   logic                  sel_front_ff, sel_front_in;
   logic                  oob_ff, oob_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   tsd_pkg::rsp_type      rsp_ff, rsp_in;

   logic [63:0]           val_wide;
   logic [DATA_WIDTH-1:0] push_data;
   logic                  front_full, back_full;
   logic                  push_front_ok, push_back_ok;
   logic [XW-1:0]         total_x, fc_x, idx_x;
   logic [AW-1:0]         front_addr, back_addr;
   logic [TW-1:0]         total_in;
   logic signed [DATA_WIDTH-1:0] rd_sel;
   logic signed [DATA_WIDTH-1:0] fv_sel, bv_sel;
   logic [63:0]           rd_wide, fv_wide, bv_wide;

   assign val_wide   = 64'(req_payload.value);
   assign push_data  = val_wide[DATA_WIDTH-1:0];
   assign front_full = (fc_ff == CW'(SIDE_DEPTH));
   assign back_full  = (bc_ff == CW'(SIDE_DEPTH));

   assign push_front_ok = cmd.accept && (req_payload.func == tsd_pkg::FUNC_PUSH_FRONT)
                          && !front_full;
   assign push_back_ok  = cmd.accept && (req_payload.func == tsd_pkg::FUNC_PUSH_BACK)
                          && !back_full;

   assign fc_x    = XW'(fc_ff);
   assign total_x = XW'(fc_ff) + XW'(bc_ff);
   assign idx_x   = XW'(req_payload.index);

   always_comb begin
      logic [XW-1:0] fa;
      logic [XW-1:0] ba;
      fa         = fc_x - XW'(1) - idx_x;
      ba         = idx_x - fc_x;
      front_addr = fa[AW-1:0];
      back_addr  = ba[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (push_front_ok) begin
         front_mem[fc_ff[AW-1:0]] <= push_data;
      end
      if (push_back_ok) begin
         back_mem[bc_ff[AW-1:0]] <= push_data;
      end
      if (cmd.accept) begin
         front_rd_ff <= front_mem[front_addr];
         back_rd_ff  <= back_mem[back_addr];
      end
   end

   always_comb begin
      fc_in        = fc_ff;
      bc_in        = bc_ff;
      front_top_in = front_top_ff;
      front_bot_in = front_bot_ff;
      back_top_in  = back_top_ff;
      back_bot_in  = back_bot_ff;
      if (push_front_ok) begin
         fc_in        = fc_ff + CW'(1);
         front_top_in = push_data;
         if (fc_ff == '0) begin
            front_bot_in = push_data;
         end
      end
      if (push_back_ok) begin
         bc_in       = bc_ff + CW'(1);
         back_top_in = push_data;
         if (bc_ff == '0) begin
            back_bot_in = push_data;
         end
      end
   end

   assign sel_front_in = (idx_x < fc_x);
   assign oob_in       = (idx_x >= total_x);
   assign total_in     = TW'(fc_in) + TW'(bc_in);

   assign rd_sel  = sel_front_ff ? front_rd_ff : back_rd_ff;
   assign rd_wide = 64'(rd_sel);
   assign fv_sel  = (fc_in != '0) ? front_top_in : back_bot_in;
   assign bv_sel  = (bc_in != '0) ? back_top_in : front_bot_in;
   assign fv_wide = 64'(fv_sel);
   assign bv_wide = 64'(bv_sel);

   always_comb begin
      rsp_in.read_data   = '0;
      rsp_in.status      = tsd_pkg::STAT_OK;
      rsp_in.count       = 10'(total_in);
      rsp_in.is_empty    = (total_in == '0);
      rsp_in.front_value = (total_in == '0) ? '0 : fv_wide[31:0];
      rsp_in.back_value  = (total_in == '0) ? '0 : bv_wide[31:0];
      rsp_valid_in       = 1'b0;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         if (oob_ff) begin
            rsp_in.status = tsd_pkg::STAT_OOR;
         end else begin
            rsp_in.read_data = rd_wide[31:0];
         end
      end else if (cmd.accept && (req_payload.func != tsd_pkg::FUNC_READ)) begin
         rsp_valid_in = 1'b1;
         if ((req_payload.func == tsd_pkg::FUNC_PUSH_FRONT && front_full) ||
             (req_payload.func == tsd_pkg::FUNC_PUSH_BACK && back_full)) begin
            rsp_in.status = tsd_pkg::STAT_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff        <= '0;
         bc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fc_ff        <= fc_in;
         bc_ff        <= bc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_top_ff <= front_top_in;
      front_bot_ff <= front_bot_in;
      back_top_ff  <= back_top_in;
      back_bot_ff  <= back_bot_in;
      rsp_ff       <= rsp_in;
      if (cmd.accept) begin
         sel_front_ff <= sel_front_in;
         oob_ff       <= oob_in;
      end
   end

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (fc_ff <= CW'(SIDE_DEPTH)) && (bc_ff <= CW'(SIDE_DEPTH)))
      else $error("stack count past its depth");

   a_read_done: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("indexed read gave no result");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == tsd_pkg::STAT_OOR)) |-> (rsp_ff.read_data == '0))
      else $error("out of range read returned data");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      push_front_ok |=> (fc_ff == $past(fc_ff) + CW'(1)))
      else $error("front push did not grow the front stack");
`endif

endmodule

// File: rtl/two_stack_deque.sv
// Top level of the two-stack deque: controller and datapath.
// Usage: a request word (func, value, index) is taken at a rising edge where start
// is high and busy is low. Each request yields exactly one result word on
// rsp_payload, marked by rsp_strobe for a single cycle; the receiver cannot stall,
// so results must be captured when the strobe is seen.
// Timing: a push at the front or back, or an unused func code, shows its result in
// the cycle after acceptance, and busy stays low, so one push per cycle is taken.
// An indexed read first reads both stack memories through their registered read
// ports, then forms the result in the read state, during which busy is high.
// The registered memory read is what makes the read state necessary.
// Every result carries the element count, the empty flag and the front and back
// elements, which are kept in registers and need no memory access.
// Reset empties both stacks at once; no clearing pass is needed because only
// entries below each stack's count are ever read.
module two_stack_deque #(
   parameter int SIDE_DEPTH = tsd_pkg::SIDE_DEPTH_DEF,
   parameter int DATA_WIDTH = tsd_pkg::DATA_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tsd_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output tsd_pkg::rsp_type rsp_payload
);

   tsd_pkg::cmd_type cmd;

   tsd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_payload.func),
      .busy     (busy),
      .cmd      (cmd)
   );

   tsd_datapath #(
      .SIDE_DEPTH (SIDE_DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the two-stack deque with random and directed words.
`timescale 1ns / 1ps

module tb_top;

   localparam int          DEPTH       = tsd_pkg::SIDE_DEPTH_DEF;
   localparam logic [1:0]  FUNC_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 200000;

   class deque_shadow;
      logic signed [31:0] front_mem [DEPTH];
      logic signed [31:0] back_mem [DEPTH];
      int unsigned        front_n;
      int unsigned        back_n;
      tsd_pkg::rsp_type   replies_due [$];
      int unsigned        mismatches;
      int unsigned        words_seen;
      int unsigned        pushes_taken;
      int unsigned        pushes_refused;
      int unsigned        reads_ok;
      int unsigned        reads_oor;

      function new();
         front_n = 0;
         back_n = 0;
         mismatches = 0;
         words_seen = 0;
         pushes_taken = 0;
         pushes_refused = 0;
         reads_ok = 0;
         reads_oor = 0;
      endfunction

      function void note_request(tsd_pkg::req_type w);
         tsd_pkg::rsp_type want;
         int unsigned      total;
         want = '0;
         want.status = tsd_pkg::STAT_OK;
         words_seen++;
         total = front_n + back_n;
         case (w.func)
            tsd_pkg::FUNC_PUSH_FRONT: begin
               if (front_n >= DEPTH) begin
                  want.status = tsd_pkg::STAT_FULL;
                  pushes_refused++;
               end else begin
                  front_mem[front_n] = w.value;
                  front_n++;
                  pushes_taken++;
               end
            end
            tsd_pkg::FUNC_PUSH_BACK: begin
               if (back_n >= DEPTH) begin
                  want.status = tsd_pkg::STAT_FULL;
                  pushes_refused++;
               end else begin
                  back_mem[back_n] = w.value;
                  back_n++;
                  pushes_taken++;
               end
            end
            tsd_pkg::FUNC_READ: begin
               if (w.index >= total) begin
                  want.status = tsd_pkg::STAT_OOR;
                  reads_oor++;
               end else begin
                  reads_ok++;
                  if (w.index < front_n) want.read_data = front_mem[front_n - 1 - w.index];
                  else want.read_data = back_mem[w.index - front_n];
               end
            end
            default: begin
            end
         endcase
         total = front_n + back_n;
         want.count = total[9:0];
         want.is_empty = (total == 0);
         if (front_n > 0) want.front_value = front_mem[front_n - 1];
         else if (back_n > 0) want.front_value = back_mem[0];
         if (back_n > 0) want.back_value = back_mem[back_n - 1];
         else if (front_n > 0) want.back_value = front_mem[0];
         replies_due.insert(replies_due.size(), want);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(tsd_pkg::rsp_type got);
         tsd_pkg::rsp_type want;
         if (replies_due.size() == 0) begin
            $error("Result word arrived with nothing expected.");
            mismatches++;
            return;
         end
         want = replies_due.pop_front();
         compare_field("read_data", want.read_data, got.read_data);
         compare_field("status", want.status, got.status);
         compare_field("count", want.count, got.count);
         compare_field("is_empty", want.is_empty, got.is_empty);
         compare_field("front_value", want.front_value, got.front_value);
         compare_field("back_value", want.back_value, got.back_value);
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   tsd_pkg::req_type req_payload;
   logic             rsp_strobe;
   tsd_pkg::rsp_type rsp_payload;

   deque_shadow shadow;
   int unsigned cycles;
   int unsigned fr_cnt;
   int unsigned bk_cnt;
   int unsigned burst_left;

   two_stack_deque dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Run stopped at the cycle limit.");
         $display("tb_top failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) shadow.note_request(req_payload);
         if (rsp_strobe) shadow.check_response(rsp_payload);
      end
   end

   task automatic send_word(logic [1:0] f, logic [31:0] v, logic [8:0] ix);
      tsd_pkg::req_type w;
      int unsigned      gap;
      w.func = f;
      w.value = v;
      w.index = ix;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_payload <= w;
      do @(posedge clock); while (busy);
      if (f == tsd_pkg::FUNC_PUSH_FRONT && fr_cnt < DEPTH) fr_cnt++;
      if (f == tsd_pkg::FUNC_PUSH_BACK && bk_cnt < DEPTH) bk_cnt++;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 11))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [8:0] pick_index();
      int unsigned total;
      total = fr_cnt + bk_cnt;
      case ($urandom_range(0, 9))
         6: return total[8:0];
         7: return (total > 0) ? total[8:0] - 9'd1 : 9'd0;
         8, 9: return 9'($urandom_range(0, 511));
         default: return (total > 0) ? 9'($urandom_range(0, total - 1)) : 9'd0;
      endcase
   endfunction

   task automatic random_word(int unsigned front_pct, int unsigned back_pct,
                              int unsigned read_pct);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < front_pct)
         send_word(tsd_pkg::FUNC_PUSH_FRONT, pick_value(), 9'($urandom_range(0, 511)));
      else if (r < front_pct + back_pct)
         send_word(tsd_pkg::FUNC_PUSH_BACK, pick_value(), 9'($urandom_range(0, 511)));
      else if (r < front_pct + back_pct + read_pct)
         send_word(tsd_pkg::FUNC_READ, pick_value(), pick_index());
      else send_word(FUNC_UNUSED, pick_value(), 9'($urandom_range(0, 511)));
   endtask

   initial begin
      logic [1:0] first_side;
      logic [1:0] other_side;
      shadow = new();
      fr_cnt = 0;
      bk_cnt = 0;
      burst_left = 0;
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // The first push picks which side is empty, so the end fallback it shows varies by seed.
      first_side = ($urandom_range(0, 1) == 0) ? tsd_pkg::FUNC_PUSH_FRONT
                                               : tsd_pkg::FUNC_PUSH_BACK;
      other_side = (first_side == tsd_pkg::FUNC_PUSH_FRONT) ? tsd_pkg::FUNC_PUSH_BACK
                                                            : tsd_pkg::FUNC_PUSH_FRONT;
      send_word(tsd_pkg::FUNC_READ, 32'h0, 9'd0);
      send_word(tsd_pkg::FUNC_READ, 32'hffff_ffff, 9'h1ff);
      send_word(FUNC_UNUSED, 32'h1234_5678, 9'h0aa);
      send_word(first_side, 32'h8000_0000, 9'h155);
      send_word(tsd_pkg::FUNC_READ, 32'h0, 9'd0);
      send_word(tsd_pkg::FUNC_READ, 32'h0, 9'd1);
      send_word(first_side, 32'hffff_ffff, 9'h0);
      send_word(other_side, 32'h7fff_ffff, 9'h0);
      send_word(other_side, 32'h0000_0000, 9'h1ff);
      send_word(tsd_pkg::FUNC_PUSH_FRONT, 32'h5555_5555, 9'h0);
      send_word(tsd_pkg::FUNC_PUSH_BACK, 32'haaaa_aaaa, 9'h0);
      for (int i = 0; i <= 6; i++) send_word(tsd_pkg::FUNC_READ, 32'h0, 9'(i));
      send_word(FUNC_UNUSED, 32'hdead_beef, 9'h1ff);

      repeat (150) random_word(30, 30, 33);
      while (fr_cnt < DEPTH || bk_cnt < DEPTH) random_word(45, 45, 10);
      repeat (60) random_word(20, 20, 55);

      start <= 1'b0;
      while (shadow.replies_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Checked %0d words: %0d pushes stored, %0d refused on a full stack.",
               shadow.words_seen, shadow.pushes_taken, shadow.pushes_refused);
      $display("Reads: %0d in range, %0d past the size; %0d mismatches.",
               shadow.reads_ok, shadow.reads_oor, shadow.mismatches);
      if (shadow.mismatches == 0 && shadow.replies_due.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
